FILE: design/uct_pkg.sv
`timescale 1ns / 1ps

package uct_pkg;

  // Request action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_UPDATE = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_LOOKUP = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // Response status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ID_ZERO   = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned MASK_W = 64;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  user_id;
    logic [MASK_W-1:0] cap_mask;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              found;
    logic [MASK_W-1:0] mask_out;
  } rsp_t;

endpackage

FILE: design/uct_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module uct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/uid_capability_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_data_i  (req_t: action, user_id, cap_mask)
// out       output     out_valid_o/out_ready_i out_data_o (rsp_t: status, found, mask_out)
//
// Every request except clear all scans the whole table through one read port of
// the key and mask RAMs, one slot per cycle; the next request is taken only after
// the result is committed. Clear all sweeps the key RAM instead.
// After reset the same sweep runs with in_ready_o low.
// The result sits in an output register; a new request is taken while it waits,
// and only the commit of the following one stalls until it has been taken.
module uid_capability_table
  import uct_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W = KEY_W + 1;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  req_t              req_q;
  logic [CNT_W-1:0]  issue_cnt_q, issue_cnt_d;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [MASK_W-1:0] hit_mask_q, hit_mask_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_data_q, out_data_d;

  logic               in_xfer;
  logic               scan_issue;
  logic               commit;
  logic               sweep_last;
  rsp_t               rsp;

  logic               key_we;
  logic [IDX_W-1:0]   key_waddr;
  logic [ENTRY_W-1:0] key_wdata;
  logic [ENTRY_W-1:0] key_rdata;
  logic               mask_we;
  logic [IDX_W-1:0]   mask_waddr;
  logic [MASK_W-1:0]  mask_wdata;
  logic [MASK_W-1:0]  mask_rdata;

  // Key RAM entry: {valid, key}
  uct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (scan_issue),
    .raddr_i(issue_cnt_q[IDX_W-1:0]),
    .rdata_o(key_rdata)
  );

  uct_ram #(
    .WIDTH(MASK_W),
    .DEPTH(TABLE_SLOTS)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (mask_we),
    .waddr_i(mask_waddr),
    .wdata_i(mask_wdata),
    .re_i   (scan_issue),
    .raddr_i(issue_cnt_q[IDX_W-1:0]),
    .rdata_o(mask_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign scan_issue = (state_q == S_SCAN) && (issue_cnt_q < CNT_W'(TABLE_SLOTS));
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign sweep_last = (sweep_q == IDX_W'(TABLE_SLOTS - 1));

  // Scan compare: first invalid slot and the matching valid slot
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_mask_d = hit_mask_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (in_xfer) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (rd_pend_q) begin
      if (key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == req_q.user_id)) begin
        hit_d      = 1'b1;
        hit_idx_d  = cmp_idx_q;
        hit_mask_d = mask_rdata;
      end
      if (!key_rdata[KEY_W] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  // Result and table update decision
  always_comb begin
    rsp.status   = ST_OK;
    rsp.found    = (req_q.action <= ACT_LOOKUP) ? hit_q : 1'b0;
    rsp.mask_out = '0;
    key_we       = 1'b0;
    key_waddr    = sweep_q;
    key_wdata    = '0;
    mask_we      = 1'b0;
    mask_waddr   = hit_idx_q;
    mask_wdata   = req_q.cap_mask;

    if ((state_q == S_INIT) || (state_q == S_CLEAR)) begin
      key_we = 1'b1;
    end else if (commit) begin
      case (req_q.action)
        ACT_ADD, ACT_SET: begin
          if (req_q.user_id == '0) begin
            rsp.status = ST_ID_ZERO;
          end else if (hit_q) begin
            if (req_q.action == ACT_ADD) begin
              rsp.status = ST_EXISTS;
            end else begin
              mask_we = 1'b1;
            end
          end else if (!free_q) begin
            rsp.status = ST_FULL;
          end else begin
            key_we     = 1'b1;
            key_waddr  = free_idx_q;
            key_wdata  = {1'b1, req_q.user_id};
            mask_we    = 1'b1;
            mask_waddr = free_idx_q;
          end
        end
        ACT_REMOVE: begin
          if (!hit_q) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            key_we    = 1'b1;
            key_waddr = hit_idx_q;
            key_wdata = {1'b0, req_q.user_id};
          end
        end
        ACT_UPDATE: begin
          if (!hit_q) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            mask_we = 1'b1;
          end
        end
        ACT_LOOKUP: begin
          if (!hit_q) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            rsp.mask_out = hit_mask_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    sweep_d     = sweep_q;
    unique case (state_q)
      S_INIT: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          issue_cnt_d = '0;
          sweep_d     = '0;
          state_d     = (in_data_i.action == ACT_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          issue_cnt_d = issue_cnt_q + 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      issue_cnt_q <= '0;
      sweep_q     <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      sweep_q     <= sweep_d;
      rd_pend_q   <= scan_issue;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
    cmp_idx_q  <= issue_cnt_q[IDX_W-1:0];
    hit_idx_q  <= hit_idx_d;
    hit_mask_q <= hit_mask_d;
    free_idx_q <= free_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A slot cannot be both the key match and the first free slot
  a_hit_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && hit_q && free_q) |-> (hit_idx_q != free_idx_q))
    else $error("hit and free slot coincide");

  // Read data only returns during a scan
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_SCAN))
    else $error("read pending outside scan");

  // No table writes while scanning
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (!key_we && !mask_we))
    else $error("table written during scan");

  // An accepted request starts a scan or a clear sweep
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_SCAN || state_q == S_CLEAR))
    else $error("accepted request did not start");

endmodule
